// ----- rtl/image_3x3_filter_u16_assert.svh -----
// Assertion macros for the 3x3 image filter.
`ifndef IMAGE_3X3_FILTER_U16_ASSERT_SVH
`define IMAGE_3X3_FILTER_U16_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define I3F_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define I3F_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i3f_pkg.sv -----
// Types and constants shared by the 3x3 image filter.
`default_nettype none
package i3f_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NEXT,
        ST_TAPS,
        ST_PREP,
        ST_DIV,
        ST_SQRT,
        ST_FIN,
        ST_EMIT,
        ST_DONE
    } i3f_state_t;

    localparam logic [1:0] MODE_BLUR   = 2'd0;
    localparam logic [1:0] MODE_EDGES  = 2'd1;
    localparam logic [1:0] MODE_CONV   = 2'd2;
    localparam logic [1:0] MODE_CENTRE = 2'd3;

    localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
    localparam logic [2:0] REG_KERNEL_TOP    = 3'd1;
    localparam logic [2:0] REG_KERNEL_MID    = 3'd2;
    localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd3;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd4;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd5;

    localparam int TAPS        = 9;
    localparam int SOBEL_TERMS = 2;
    localparam int CMP_W       = 15;
    localparam int MUL_W       = 20;
    localparam int ACC_W       = 40;
    localparam int DIV_W       = 34;
    localparam int DIV_CNT_W   = 6;
    localparam int SQ_W        = 38;
    localparam int BLUR_SCALE  = 9;
    // Rounded-up 2^23/9; exact for every numerator below 2^21.
    localparam logic [19:0] BLUR_RECIP = 20'd932068;
    localparam int BLUR_SHIFT  = 23;
    localparam logic [15:0] PIX_MAX = 16'hffff;

endpackage
`default_nettype wire

// ----- rtl/i3f_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module i3f_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire                                   aclk,
    input  wire                                   we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire [WIDTH-1:0]                       wdata,
    input  wire                                   re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

// ----- rtl/image_3x3_filter_u16.sv -----
// Top level of the streaming 3x3 image filter with two line stores.
// Each accepted word is loaded into the window from the line stores; each owed result then
// takes nine taps and a 34-step divider in convolve mode, nine taps in blur and centre modes
// (then a multiply by one ninth for blur), two Sobel terms and a square root in edge mode.
// One word at a time, 0 to 4 results each; no new word is taken until all are sent.
// Reset (aresetn low, synchronous) clears control, registers, counters and window only.
`default_nettype none
module image_3x3_filter_u16 #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input pixel channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [15:0] s_pixel_in,
    // Result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic [15:0] m_pixel_out,
    output logic [11:0] m_out_col,
    output logic [11:0] m_out_row,
    output logic        m_last_of_run,
    output logic        m_end_of_frame,
    // Configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import i3f_pkg::*;

    `include "image_3x3_filter_u16_assert.svh"

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this, and the datapath reads them live.
    // ------------------------------------------------------------------
    logic [1:0]  mode_reg;
    logic [35:0] kern_reg [3];
    logic [12:0] width_reg;
    logic [12:0] height_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_FILTER_MODE:   prdata = {62'd0, mode_reg};
            REG_KERNEL_TOP:    prdata = {28'd0, kern_reg[0]};
            REG_KERNEL_MID:    prdata = {28'd0, kern_reg[1]};
            REG_KERNEL_BOTTOM: prdata = {28'd0, kern_reg[2]};
            REG_IMAGE_WIDTH:   prdata = {51'd0, width_reg};
            REG_IMAGE_HEIGHT:  prdata = {51'd0, height_reg};
            default:           prdata = 64'd0;
        endcase
    end

    // Frame size clamped to 1..MAX so that an out-of-range value still works.
    logic [CMP_W-1:0] wc;
    logic [CMP_W-1:0] hc;

    always_comb begin
        if (width_reg == 13'd0) begin
            wc = CMP_W'(1);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            wc = CMP_W'(MAX_WIDTH);
        end else begin
            wc = CMP_W'(width_reg);
        end
        if (height_reg == 13'd0) begin
            hc = CMP_W'(1);
        end else if (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT)) begin
            hc = CMP_W'(MAX_HEIGHT);
        end else begin
            hc = CMP_W'(height_reg);
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    i3f_state_t state_reg;
    i3f_state_t state_next;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] c_reg;       // column of the word in work
    logic [RW-1:0] r_reg;       // row of the word in work
    logic [15:0]   pix_reg;
    logic [15:0]   cur_reg [3]; // rows two above, one above and current
    logic [15:0]   win_reg [6]; // [0..2] column c-1, [3..5] column c-2
    logic [3:0]    mask_reg;    // results still owed for this word
    logic [1:0]    cand_reg;    // bit 1: row pass, bit 0: column side
    logic          last_reg;
    logic [3:0]    tap_reg;

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [15:0]      scale_reg;

    logic [14:0]          rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [14:0]          dsr_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    logic [SQ_W-1:0] sqn_reg;
    logic [SQ_W-1:0] sqr_reg;
    logic [SQ_W-1:0] sqb_reg;

    logic        m_valid_reg;
    logic [15:0] m_pixel_reg;
    logic [11:0] m_col_reg;
    logic [11:0] m_row_reg;
    logic        m_last_reg;
    logic        m_eof_reg;

    logic s_accept;
    logic ram_re;
    logic ram_we;

    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Line stores: both are read at the accepted word's column and written
    // back at that column in the next cycle, when the read data is back. The
    // next read only comes with the next word, so the two never overlap.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] row_ext;
    logic [CW-1:0]    col_eff;
    logic [RW-1:0]    row_eff;
    logic [15:0]      upper_rd;
    logic [15:0]      lower_rd;

    assign col_ext = CMP_W'(col_reg);
    assign row_ext = CMP_W'(row_reg);
    assign col_eff = (col_ext >= wc) ? CW'(0) : col_reg;
    assign row_eff = (row_ext >= hc) ? RW'(0) : row_reg;

    i3f_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_upper (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (lower_rd),
        .re    (ram_re),
        .raddr (col_eff),
        .rdata (upper_rd)
    );

    i3f_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_lower (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (c_reg),
        .wdata (pix_reg),
        .re    (ram_re),
        .raddr (col_eff),
        .rdata (lower_rd)
    );

    // ------------------------------------------------------------------
    // Window selection for the result in work, with edge replication.
    // ------------------------------------------------------------------
    logic [CMP_W-1:0] c_ext;
    logic [CMP_W-1:0] r_ext;
    logic             side;
    logic             pass;
    logic [15:0]      col_l [3];
    logic [15:0]      col_m [3];
    logic [15:0]      col_r [3];
    logic [1:0]       rs    [3];
    logic [15:0]      v_arr [TAPS];
    logic [11:0]      k_arr [TAPS];

    assign c_ext = CMP_W'(c_reg);
    assign r_ext = CMP_W'(r_reg);
    assign side  = cand_reg[0];
    assign pass  = cand_reg[1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!side) begin
                col_l[i] = (c_ext == CMP_W'(1)) ? win_reg[i] : win_reg[3 + i];
                col_m[i] = win_reg[i];
                col_r[i] = cur_reg[i];
            end else begin
                col_l[i] = (c_ext == CMP_W'(0)) ? cur_reg[i] : win_reg[i];
                col_m[i] = cur_reg[i];
                col_r[i] = cur_reg[i];
            end
        end
        if (!pass) begin
            rs[0] = (r_ext == CMP_W'(1)) ? 2'd1 : 2'd0;
            rs[1] = 2'd1;
            rs[2] = 2'd2;
        end else begin
            rs[0] = (r_ext == CMP_W'(0)) ? 2'd2 : 2'd1;
            rs[1] = 2'd2;
            rs[2] = 2'd2;
        end
        for (int i = 0; i < 3; i++) begin
            v_arr[3 * i]     = col_l[rs[i]];
            v_arr[3 * i + 1] = col_m[rs[i]];
            v_arr[3 * i + 2] = col_r[rs[i]];
            for (int j = 0; j < 3; j++) begin
                k_arr[3 * i + j] = kern_reg[i][12 * j +: 12];
            end
        end
    end

    // ------------------------------------------------------------------
    // Multiply-accumulate over the taps: one product a cycle, registered,
    // and added in the cycle after.
    // ------------------------------------------------------------------
    logic [3:0]              ntaps;
    logic [3:0]              tap_idx;
    logic [15:0]             v_sel;
    logic [11:0]             k_sel;
    logic signed [MUL_W-1:0] sob1;
    logic signed [MUL_W-1:0] sob2;
    logic signed [MUL_W-1:0] vx   [TAPS];
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;

    assign ntaps   = (mode_reg == MODE_EDGES) ? 4'(SOBEL_TERMS) : 4'(TAPS);
    assign tap_idx = (tap_reg < 4'(TAPS)) ? tap_reg : 4'd0;
    assign v_sel   = v_arr[tap_idx];
    assign k_sel   = k_arr[tap_idx];

    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            vx[i] = $signed({4'd0, v_arr[i]});
        end
        sob1 = vx[0] + (vx[1] <<< 1) + vx[2] - vx[6] - (vx[7] <<< 1) - vx[8];
        sob2 = vx[0] + (vx[3] <<< 1) + vx[6] - vx[2] - (vx[5] <<< 1) - vx[8];
        case (mode_reg)
            MODE_EDGES: begin
                mul_a = (tap_reg == 4'd0) ? sob1 : sob2;
                mul_b = mul_a;
            end
            MODE_CONV: begin
                mul_a = $signed({{8{k_sel[11]}}, k_sel});
                mul_b = $signed({4'd0, v_sel});
            end
            default: begin
                mul_a = MUL_W'(1);
                mul_b = $signed({4'd0, v_sel});
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Divider set-up. Blur rounds with a scale of nine but takes its
    // quotient from a reciprocal multiplication; a zero kernel sum divides
    // by one.
    // ------------------------------------------------------------------
    logic signed [15:0]      sc;
    logic signed [15:0]      half;
    logic signed [15:0]      sc_abs;
    logic signed [ACC_W-1:0] dvd;
    logic signed [ACC_W-1:0] dvd_abs;

    always_comb begin
        if (mode_reg == MODE_CONV) begin
            sc = (scale_reg == 16'sd0) ? 16'sd1 : scale_reg;
        end else begin
            sc = 16'(BLUR_SCALE);
        end
        half    = (sc + $signed({15'd0, sc[15]})) >>> 1;
        dvd     = acc_reg + ACC_W'(half);
        dvd_abs = dvd[ACC_W-1] ? -dvd : dvd;
        sc_abs  = sc[15] ? -sc : sc;
    end

    // Blur quotient: the rounded sum is below 2^20, so multiplying by the
    // rounded-up reciprocal of nine and dropping the low bits is exact.
    logic [19:0] blur_num;
    logic [39:0] blur_prod;
    logic [16:0] blur_q;

    assign blur_num  = dvd[19:0];
    assign blur_prod = blur_num * BLUR_RECIP;
    assign blur_q    = blur_prod[39:BLUR_SHIFT];

    // One restoring division step a cycle.
    logic [15:0] div_trial;
    logic        div_ge;

    assign div_trial = {rem_reg, quo_reg[DIV_W-1]};
    assign div_ge    = div_trial >= {1'b0, dsr_reg};

    // One square-root step a cycle.
    logic [SQ_W:0] sq_trial;
    logic          sq_ge;

    assign sq_trial = {1'b0, sqr_reg} + {1'b0, sqb_reg};
    assign sq_ge    = {1'b0, sqn_reg} >= sq_trial;

    // Result selection and the fields that travel with it.
    logic [15:0]      res_val;
    logic [CMP_W-1:0] ocol;
    logic [CMP_W-1:0] orow;

    always_comb begin
        case (mode_reg)
            MODE_BLUR, MODE_CONV: begin
                if (neg_reg) begin
                    res_val = 16'd0;
                end else if (quo_reg > DIV_W'(PIX_MAX)) begin
                    res_val = PIX_MAX;
                end else begin
                    res_val = quo_reg[15:0];
                end
            end
            MODE_EDGES: begin
                res_val = (sqr_reg > SQ_W'(PIX_MAX)) ? PIX_MAX : sqr_reg[15:0];
            end
            default: begin
                res_val = v_arr[4];
            end
        endcase
        ocol = side ? c_ext : c_ext - CMP_W'(1);
        orow = pass ? r_ext : r_ext - CMP_W'(1);
    end

    // Next owed result: the lowest bit of the mask.
    logic [1:0] cand_pick;
    logic [3:0] mask_left;

    always_comb begin
        if (mask_reg[0]) begin
            cand_pick = 2'd0;
        end else if (mask_reg[1]) begin
            cand_pick = 2'd1;
        end else if (mask_reg[2]) begin
            cand_pick = 2'd2;
        end else begin
            cand_pick = 2'd3;
        end
        mask_left = mask_reg & ~(4'd1 << cand_pick);
    end

    // Next-column and next-row values for the counters.
    logic [CMP_W-1:0] col_inc;
    logic [CMP_W-1:0] row_inc;

    assign col_inc = c_ext + CMP_W'(1);
    assign row_inc = r_ext + CMP_W'(1);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: state_next = ST_NEXT;
            ST_NEXT: state_next = (mask_reg == 4'd0) ? ST_DONE : ST_TAPS;
            ST_TAPS: begin
                if (tap_reg == ntaps) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                case (mode_reg)
                    MODE_EDGES:             state_next = ST_SQRT;
                    MODE_BLUR, MODE_CENTRE: state_next = ST_FIN;
                    default:                state_next = ST_DIV;
                endcase
            end
            ST_DIV: begin
                if (cnt_reg == DIV_CNT_W'(0)) begin
                    state_next = ST_FIN;
                end
            end
            ST_SQRT: begin
                if (sqb_reg[0]) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: state_next = ST_EMIT;
            ST_EMIT: begin
                if (m_ready) begin
                    state_next = ST_NEXT;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        ram_re  = s_accept;
        ram_we  = (state_reg == ST_LOAD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_BLUR;
            kern_reg[0] <= 36'd0;
            kern_reg[1] <= 36'd0;
            kern_reg[2] <= 36'd0;
            width_reg   <= 13'd4096;
            height_reg  <= 13'd4096;
            col_reg     <= CW'(0);
            row_reg     <= RW'(0);
            mask_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= 16'd0;
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                case (cfg_idx)
                    REG_FILTER_MODE:   mode_reg    <= pwdata[1:0];
                    REG_KERNEL_TOP:    kern_reg[0] <= pwdata[35:0];
                    REG_KERNEL_MID:    kern_reg[1] <= pwdata[35:0];
                    REG_KERNEL_BOTTOM: kern_reg[2] <= pwdata[35:0];
                    REG_IMAGE_WIDTH:   width_reg   <= pwdata[12:0];
                    REG_IMAGE_HEIGHT:  height_reg  <= pwdata[12:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        c_reg   <= col_eff;
                        r_reg   <= row_eff;
                        pix_reg <= s_pixel_in;
                    end
                end
                ST_LOAD: begin
                    cur_reg[0] <= upper_rd;
                    cur_reg[1] <= lower_rd;
                    cur_reg[2] <= pix_reg;
                    mask_reg[0] <= (r_ext != CMP_W'(0)) && (c_ext != CMP_W'(0));
                    mask_reg[1] <= (r_ext != CMP_W'(0)) && (c_ext == wc - CMP_W'(1));
                    mask_reg[2] <= (r_ext == hc - CMP_W'(1)) && (c_ext != CMP_W'(0));
                    mask_reg[3] <= (r_ext == hc - CMP_W'(1)) && (c_ext == wc - CMP_W'(1));
                end
                ST_NEXT: begin
                    cand_reg  <= cand_pick;
                    mask_reg  <= mask_left;
                    last_reg  <= (mask_left == 4'd0);
                    tap_reg   <= 4'd0;
                    acc_reg   <= '0;
                    scale_reg <= 16'sd0;
                end
                ST_TAPS: begin
                    if (tap_reg < ntaps) begin
                        prod_reg  <= mul_a * mul_b;
                        scale_reg <= scale_reg + $signed({{4{k_sel[11]}}, k_sel});
                    end
                    if (tap_reg != 4'd0) begin
                        acc_reg <= acc_reg + prod_reg;
                    end
                    tap_reg <= tap_reg + 4'd1;
                end
                ST_PREP: begin
                    rem_reg <= 15'd0;
                    quo_reg <= (mode_reg == MODE_BLUR) ? DIV_W'(blur_q)
                                                       : dvd_abs[DIV_W-1:0];
                    dsr_reg <= sc_abs[14:0];
                    neg_reg <= dvd[ACC_W-1] ^ sc[15];
                    cnt_reg <= DIV_CNT_W'(DIV_W - 1);
                    sqn_reg <= acc_reg[SQ_W-1:0];
                    sqr_reg <= '0;
                    sqb_reg <= SQ_W'(1) << (SQ_W - 2);
                end
                ST_DIV: begin
                    rem_reg <= div_ge ? 15'(div_trial - {1'b0, dsr_reg}) : div_trial[14:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], div_ge};
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        sqn_reg <= SQ_W'({1'b0, sqn_reg} - sq_trial);
                        sqr_reg <= (sqr_reg >> 1) + sqb_reg;
                    end else begin
                        sqr_reg <= sqr_reg >> 1;
                    end
                    sqb_reg <= sqb_reg >> 2;
                end
                ST_FIN: begin
                    m_valid_reg <= 1'b1;
                    m_pixel_reg <= res_val;
                    m_col_reg   <= ocol[11:0];
                    m_row_reg   <= orow[11:0];
                    m_last_reg  <= last_reg;
                    m_eof_reg   <= (orow == hc - CMP_W'(1)) && (ocol == wc - CMP_W'(1));
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_DONE: begin
                    // Shift the window by one column and step the raster position.
                    for (int i = 0; i < 3; i++) begin
                        win_reg[3 + i] <= win_reg[i];
                        win_reg[i]     <= cur_reg[i];
                    end
                    if (col_inc >= wc) begin
                        col_reg <= CW'(0);
                        row_reg <= (row_inc >= hc) ? RW'(0) : RW'(row_inc);
                    end else begin
                        col_reg <= CW'(col_inc);
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_out    = m_pixel_reg;
    assign m_out_col      = m_col_reg;
    assign m_out_row      = m_row_reg;
    assign m_last_of_run  = m_last_reg;
    assign m_end_of_frame = m_eof_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `I3F_ASSERT_NOW(a_idle_no_result, s_ready, !m_valid, "input taken while a result waits")
    `I3F_ASSERT_NOW(a_ram_no_overlap, ram_we, !ram_re, "line store read during write-back")
    `I3F_ASSERT_NEXT(a_accept_load, s_accept, state_reg == ST_LOAD, "word not loaded")
    `I3F_ASSERT_NOW(a_last_mask, m_valid && m_last_of_run, mask_reg == 4'd0,
                    "last result flagged while results are still owed")
    `I3F_ASSERT_NOW(a_eof_last, m_valid && m_end_of_frame, m_last_of_run,
                    "end of frame not on the final result of its word")
endmodule
`default_nettype wire

// ----- tb/image_3x3_filter_u16_test.sv -----
// Self-checking testbench for the streaming 3x3 image filter, with its own prediction of every result.
`default_nettype none
module image_3x3_filter_u16_test;
    timeunit 1ns;
    timeprecision 1ps;
    import i3f_pkg::*;

    // One filtered pixel as the result channel should carry it.
    typedef struct {
        logic [15:0] pix;
        logic [11:0] col;
        logic [11:0] row;
        logic        last;
        logic        eof;
    } filt_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    wire         s_ready;
    logic [15:0] s_pixel_in;
    wire         m_valid;
    logic        m_ready;
    wire  [15:0] m_pixel_out;
    wire  [11:0] m_out_col;
    wire  [11:0] m_out_row;
    wire         m_last_of_run;
    wire         m_end_of_frame;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    wire  [63:0] prdata;
    wire         pready;

    image_3x3_filter_u16 dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_pixel_in(s_pixel_in),
        .m_valid(m_valid), .m_ready(m_ready), .m_pixel_out(m_pixel_out),
        .m_out_col(m_out_col), .m_out_row(m_out_row),
        .m_last_of_run(m_last_of_run), .m_end_of_frame(m_end_of_frame),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor copy of the configuration and of the block's state.
    logic [1:0]  cfg_mode;
    logic [35:0] cfg_kernel [3];
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [15:0] upper_line [4096];
    logic [15:0] lower_line [4096];
    logic [15:0] win_prev1 [3];
    logic [15:0] win_prev2 [3];
    int unsigned pos_col;
    int unsigned pos_row;

    logic [15:0] pixel_backlog [$];  // words still to be offered on s_
    filt_word_t  filt_expect_q [$];  // predicted results awaiting the m_ channel
    int          errors;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        rx_hold;
    logic        rx_hold_go;
    logic        in_taken;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned clamp_size(input logic [12:0] v);
        if (v < 1) return 1;
        if (v > 4096) return 4096;
        return 32'(v);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Neighbourhood v[0..8] in raster order, top-left first.
    function automatic logic [15:0] filter_nbhd(input logic [15:0] v [9]);
        longint s1;
        longint s2;
        longint acc;
        longint scale;
        longint k;
        longint unsigned q;
        int unsigned sum;
        case (cfg_mode)
            MODE_BLUR: begin
                sum = 4;
                for (int i = 0; i < 9; i++) sum += v[i];
                return 16'(sum / 9);
            end
            MODE_EDGES: begin
                s1 = longint'(v[0]) + 2 * longint'(v[1]) + v[2] - v[6] - 2 * longint'(v[7]) - v[8];
                s2 = longint'(v[0]) + 2 * longint'(v[3]) + v[6] - v[2] - 2 * longint'(v[5]) - v[8];
                q = s1 * s1 + s2 * s2;
                q = int_sqrt(q);
                return (q > 65535) ? 16'hffff : q[15:0];
            end
            MODE_CONV: begin
                acc = 0;
                scale = 0;
                for (int i = 0; i < 9; i++) begin
                    k = longint'(signed'(cfg_kernel[i / 3][12 * (i % 3) +: 12]));
                    acc += k * longint'(v[i]);
                    scale += k;
                end
                if (scale == 0) scale = 1;
                // SystemVerilog division truncates toward zero, as required.
                acc = (acc + scale / 2) / scale;
                if (acc > 65535) acc = 65535;
                if (acc < 0) acc = 0;
                return acc[15:0];
            end
            default: return v[4];
        endcase
    endfunction

    // Advance the predicted state by one accepted pixel and queue its results.
    function automatic void predict_pixel(input logic [15:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned orow;
        int unsigned ocol;
        int rs [3];
        int lc;
        int mc;
        int rc;
        int n;
        logic [15:0] cols [3][3];
        logic [15:0] v [9];
        filt_word_t fw;
        w = clamp_size(cfg_width);
        h = clamp_size(cfg_height);
        if (pos_col >= w) pos_col = 0;
        if (pos_row >= h) pos_row = 0;
        c = pos_col;
        r = pos_row;
        // Column 0 is two back, column 1 one back, column 2 the current one.
        cols[2][0] = upper_line[c];
        cols[2][1] = lower_line[c];
        cols[2][2] = pix;
        for (int i = 0; i < 3; i++) begin
            cols[1][i] = win_prev1[i];
            cols[0][i] = win_prev2[i];
        end
        n = 0;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0 && r < 1) continue;
            if (pass == 1 && r != h - 1) continue;
            if (pass == 0) begin
                orow = r - 1;
                rs = '{(orow == 0) ? 1 : 0, 1, 2};
            end else begin
                orow = r;
                rs = '{(r == 0) ? 2 : 1, 2, 2};
            end
            for (int side = 0; side < 2; side++) begin
                if (side == 0 && c < 1) continue;
                if (side == 1 && c != w - 1) continue;
                if (side == 0) begin
                    ocol = c - 1;
                    lc = (ocol == 0) ? 1 : 0;
                    mc = 1;
                    rc = 2;
                end else begin
                    ocol = c;
                    lc = (c == 0) ? 2 : 1;
                    mc = 2;
                    rc = 2;
                end
                for (int i = 0; i < 3; i++) begin
                    v[3 * i]     = cols[lc][rs[i]];
                    v[3 * i + 1] = cols[mc][rs[i]];
                    v[3 * i + 2] = cols[rc][rs[i]];
                end
                fw.pix  = filter_nbhd(v);
                fw.col  = ocol[11:0];
                fw.row  = orow[11:0];
                fw.last = 1'b0;
                fw.eof  = (orow == h - 1 && ocol == w - 1);
                filt_expect_q.push_back(fw);
                n++;
            end
        end
        if (n > 0) filt_expect_q[filt_expect_q.size() - 1].last = 1'b1;
        upper_line[c] = cols[2][1];
        lower_line[c] = pix;
        for (int i = 0; i < 3; i++) begin
            win_prev2[i] = cols[1][i];
            win_prev1[i] = cols[2][i];
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        pos_col = c;
        pos_row = r;
    endfunction

    // Rising edge: note the accepted input word and check the accepted result word.
    always @(posedge aclk) begin
        filt_word_t fw;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) predict_pixel(s_pixel_in);
        if (aresetn && m_valid && m_ready) begin
            if (filt_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word pix=%h col=%0d row=%0d", $time,
                         m_pixel_out, m_out_col, m_out_row);
            end else begin
                fw = filt_expect_q.pop_front();
                if (m_pixel_out !== fw.pix || m_out_col !== fw.col || m_out_row !== fw.row
                        || m_last_of_run !== fw.last || m_end_of_frame !== fw.eof) begin
                    errors++;
                    $display("%0t: mismatch expected pix=%h col=%0d row=%0d last=%b eof=%b",
                             $time, fw.pix, fw.col, fw.row, fw.last, fw.eof);
                    $display("%0t:          actual   pix=%h col=%0d row=%0d last=%b eof=%b",
                             $time, m_pixel_out, m_out_col, m_out_row, m_last_of_run,
                             m_end_of_frame);
                end
            end
        end
    end

    // Falling edge: offer the next pixel word once the current one has gone, and
    // decide whether the receiver takes a word in the coming cycle.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (pixel_backlog.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_valid    <= 1'b1;
                s_pixel_in <= pixel_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // A long receiver stall, so that the block backs up and refuses input words.
    initial begin
        rx_hold = 1'b0;
        @(posedge rx_hold_go);
        @(negedge aclk);
        rx_hold = 1'b1;
        repeat (600) @(posedge aclk);
        @(negedge aclk);
        rx_hold = 1'b0;
    end

    initial begin
        #50ms;
        $display("image_3x3_filter_u16_test failed");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        // Mirror the write with the register widths applied.
        case (idx)
            REG_FILTER_MODE:   cfg_mode      = val[1:0];
            REG_KERNEL_TOP:    cfg_kernel[0] = val[35:0];
            REG_KERNEL_MID:    cfg_kernel[1] = val[35:0];
            REG_KERNEL_BOTTOM: cfg_kernel[2] = val[35:0];
            REG_IMAGE_WIDTH:   cfg_width     = val[12:0];
            REG_IMAGE_HEIGHT:  cfg_height    = val[12:0];
            default: ;
        endcase
    endtask

    // Wait until every word is offered and every result is in, then for the
    // longest time a result-free word can still be in the pipeline.
    task automatic drain;
        wait (pixel_backlog.size() == 0 && !s_valid && filt_expect_q.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    function automatic logic [11:0] rand_coef;
        case ($urandom_range(5))
            0: return 12'h7ff;
            1: return 12'h800;
            2: return 12'($urandom_range(4));
            default: return 12'($urandom);
        endcase
    endfunction

    // Configure the block for a whole frame and queue its pixels.
    // style: 0 random, 1 all white, 2 black and white checkerboard.
    task automatic run_frame(input logic [1:0] mode, input logic [35:0] kt,
                             input logic [35:0] km, input logic [35:0] kb,
                             input logic [12:0] w, input logic [12:0] h, input int style);
        int unsigned we;
        int unsigned he;
        logic [15:0] p;
        drain();
        write_reg(REG_FILTER_MODE, 64'(mode));
        write_reg(REG_KERNEL_TOP, 64'(kt));
        write_reg(REG_KERNEL_MID, 64'(km));
        write_reg(REG_KERNEL_BOTTOM, 64'(kb));
        write_reg(REG_IMAGE_WIDTH, 64'(w));
        write_reg(REG_IMAGE_HEIGHT, 64'(h));
        we = clamp_size(w);
        he = clamp_size(h);
        for (int r = 0; r < he; r++) begin
            for (int c = 0; c < we; c++) begin
                case (style)
                    1: p = 16'hffff;
                    2: p = ((r + c) % 2) ? 16'hffff : 16'h0000;
                    default: begin
                        case ($urandom_range(7))
                            0: p = 16'h0000;
                            1: p = 16'hffff;
                            default: p = 16'($urandom);
                        endcase
                    end
                endcase
                pixel_backlog.push_back(p);
            end
        end
    endtask

    // Random frames of mostly small sizes until about n pixels have been queued.
    task automatic random_frames(input int n);
        int sent;
        logic [12:0] w;
        logic [12:0] h;
        logic [35:0] k [3];
        sent = 0;
        while (sent < n) begin
            w = ($urandom_range(9) == 0) ? 13'd40 : 13'($urandom_range(1, 12));
            h = 13'($urandom_range(1, 6));
            for (int i = 0; i < 3; i++) k[i] = {rand_coef(), rand_coef(), rand_coef()};
            if ($urandom_range(3) == 0) begin
                // Coefficients summing to zero, so the scale falls back to one.
                k[0] = {12'hfff, 12'hfff, 12'hfff};
                k[1] = {12'hfff, 12'h008, 12'hfff};
                k[2] = {12'hfff, 12'hfff, 12'hfff};
            end
            run_frame(2'($urandom_range(3)), k[0], k[1], k[2], w, h, 0);
            sent += int'(w) * int'(h);
        end
    endtask

    initial begin
        errors        = 0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        rx_hold_go    = 1'b0;
        in_taken      = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel_in    = 16'h0000;
        m_ready       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_mode      = MODE_BLUR;
        cfg_kernel    = '{default: '0};
        cfg_width     = 13'd4096;
        cfg_height    = 13'd4096;
        win_prev1     = '{default: '0};
        win_prev2     = '{default: '0};
        pos_col       = 0;
        pos_row       = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed frames: extreme pixels, every mode, extreme kernels and sizes
        // that fall outside the legal range and are clamped.
        run_frame(MODE_BLUR, '0, '0, '0, 13'd3, 13'd3, 1);
        run_frame(MODE_EDGES, '0, '0, '0, 13'd2, 13'd2, 2);
        run_frame(MODE_CONV, {3{12'h7ff}}, {3{12'h7ff}}, {3{12'h7ff}}, 13'd2, 13'd1, 0);
        run_frame(MODE_CONV, {3{12'h800}}, {3{12'h800}}, {3{12'h800}}, 13'd2, 13'd2, 2);
        run_frame(MODE_CENTRE, '1, '1, '1, 13'd3, 13'd1, 0);
        run_frame(MODE_BLUR, '0, '0, '0, 13'd0, 13'd0, 0);

        // Sender idles rarely, receiver often; the receiver also stalls for a
        // long stretch while words keep coming, so the input backs up.
        tx_idle_pct = 13;
        rx_idle_pct = 68;
        random_frames(60);
        rx_hold_go = 1'b1;
        random_frames(60);

        tx_idle_pct = 68;
        rx_idle_pct = 13;
        random_frames(100);

        // No idling at all.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_frames(80);

        drain();
        if (errors == 0) begin
            $display("image_3x3_filter_u16_test passed");
        end else begin
            $display("image_3x3_filter_u16_test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
